// ===== design/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

	localparam int unsigned NUM_CELLS = 16;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned CNT_W     = $clog2(NUM_CELLS + 1);
	localparam int unsigned IDLE_W    = 16;
	localparam int unsigned RTT_W     = 32;
	localparam int unsigned METH_W    = 3;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic REQ_SELECT = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	localparam logic REG_METHOD = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef enum logic [METH_W-1:0] {
		METH_LOW_RTT     = 3'd0,
		METH_MOST_IDLE   = 3'd1,
		METH_ROUND_ROBIN = 3'd2,
		METH_FIRST_IDLE  = 3'd3,
		METH_RANDOM      = 3'd4
	} method_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// running result carried from cell to cell during a scan
	typedef struct packed {
		logic              valid;
		logic              has_best;
		logic [RTT_W-1:0]  best_rtt;
		logic [IDX_W-1:0]  rtt_idx;
		logic [IDLE_W-1:0] best_idle;
		logic [IDX_W-1:0]  idle_idx;
		logic              fidle_found;
		logic [IDX_W-1:0]  fidle_idx;
	} scan_t;

	// statistics write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [IDLE_W-1:0] idle;
		logic [RTT_W-1:0]  rtt;
	} wr_t;

endpackage
`default_nettype wire

// ===== design/lbs_cell.sv =====
`default_nettype none
module lbs_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lbs_pkg::IDX_W-1:0] cell_idx,
	input  wire logic [lbs_pkg::CNT_W-1:0] n_live,
	input  wire lbs_pkg::wr_t              wr,
	input  wire lbs_pkg::scan_t            scan_in,
	output lbs_pkg::scan_t                 scan_out
);
	import lbs_pkg::*;

	logic [IDLE_W-1:0] idle_q;
	logic [RTT_W-1:0]  rtt_q;
	scan_t             scan_d;
	scan_t             scan_q;
	logic              active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			rtt_q  <= '0;
		end else if (wr.en && wr.idx == cell_idx) begin
			idle_q <= wr.idle;
			rtt_q  <= wr.rtt;
		end
	end

	// cells at or beyond the live count only pass the token along
	assign active = scan_in.valid && (CNT_W'(cell_idx) < n_live);

	always_comb begin
		scan_d = scan_in;
		if (active) begin
			if (!scan_in.has_best || rtt_q < scan_in.best_rtt) begin
				scan_d.best_rtt = rtt_q;
				scan_d.rtt_idx  = cell_idx;
			end
			if (!scan_in.has_best || idle_q > scan_in.best_idle) begin
				scan_d.best_idle = idle_q;
				scan_d.idle_idx  = cell_idx;
			end
			scan_d.has_best = 1'b1;
			if (!scan_in.fidle_found && idle_q != '0) begin
				scan_d.fidle_found = 1'b1;
				scan_d.fidle_idx   = cell_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	assign scan_out = scan_q;

endmodule
`default_nettype wire

// ===== design/lbs_ctrl.sv =====
`default_nettype none
module lbs_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      req_type,
	input  wire logic [lbs_pkg::IDX_W-1:0] entry,
	input  wire logic [lbs_pkg::IDLE_W-1:0] idle_conns,
	input  wire logic [lbs_pkg::RTT_W-1:0] rtt_us,
	input  wire lbs_pkg::method_t          method,
	input  wire logic [lbs_pkg::CNT_W-1:0] n_live,
	input  wire lbs_pkg::scan_t            scan_tail,
	output lbs_pkg::scan_t                 scan_head,
	output lbs_pkg::wr_t                   wr,
	output logic                           busy,
	output logic                           done,
	output logic                           found,
	output logic [lbs_pkg::IDX_W-1:0]      chosen
);
	import lbs_pkg::*;

	state_t           state_q, state_d;
	logic             accept;
	logic             is_sel;
	logic             scan_meth;
	logic             launch;
	logic [CNT_W-1:0] rr_inc;
	logic [IDX_W-1:0] rr_next;
	logic             rr_take;
	logic [IDX_W-1:0] last_pick_q;
	logic             last_valid_q;
	logic             done_q, done_d;
	logic             found_q, found_d;
	logic [IDX_W-1:0] chosen_q, chosen_d;

	assign accept = start && (state_q == ST_IDLE);
	assign is_sel = (req_type == REQ_SELECT);

	always_comb begin
		unique case (method)
			METH_LOW_RTT, METH_MOST_IDLE, METH_FIRST_IDLE: scan_meth = 1'b1;
			default:                                       scan_meth = 1'b0;
		endcase
	end

	assign launch = accept && is_sel && scan_meth && (n_live != '0);

	assign rr_inc  = CNT_W'(last_pick_q) + CNT_W'(1);
	assign rr_next = (!last_valid_q || rr_inc >= n_live) ? '0 : rr_inc[IDX_W-1:0];
	// the pointer moves only when two or more servers are live
	assign rr_take = accept && is_sel && (method == METH_ROUND_ROBIN) && (n_live >= CNT_W'(2));

	always_comb begin
		scan_head             = '0;
		scan_head.valid       = launch;
		wr.en                 = accept && (req_type == REQ_UPDATE);
		wr.idx                = entry;
		wr.idle               = idle_conns;
		wr.rtt                = rtt_us;
		state_d               = state_q;
		done_d                = 1'b0;
		found_d               = 1'b0;
		chosen_d              = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (launch) begin
					state_d = ST_SCAN;
				end else if (accept && is_sel) begin
					done_d = 1'b1;
					if (n_live != '0 && method == METH_ROUND_ROBIN) begin
						found_d  = 1'b1;
						chosen_d = rr_take ? rr_next : '0;
					end
				end
			end
			ST_SCAN: begin
				if (scan_tail.valid) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
					found_d = 1'b1;
					unique case (method)
						METH_LOW_RTT:    chosen_d = scan_tail.rtt_idx;
						METH_MOST_IDLE:  chosen_d = scan_tail.idle_idx;
						METH_FIRST_IDLE: chosen_d = scan_tail.fidle_found
						                            ? scan_tail.fidle_idx : '0;
						default:         chosen_d = '0;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			last_pick_q  <= '0;
			last_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (rr_take) begin
				last_pick_q  <= rr_next;
				last_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		found_q  <= found_d;
		chosen_q <= chosen_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign found  = done_q && found_q;
	assign chosen = found ? chosen_q : '0;

endmodule
`default_nettype wire

// ===== design/upstream_load_balance_selector.sv =====
`default_nettype none
// Backend server selector.
// Requests enter on start while busy is low. req_type 1 writes idle_conns and
// rtt_us into table entry 'entry' at the accepting edge and gives no result.
// req_type 0 selects a server among the first server_count entries under the
// configured method; the result is shown on found/chosen for one cycle with
// done high, and cannot be held off by the receiver.
// Lowest rtt, most idle and first idle run a token down a row of sixteen
// cells, one cell per cycle, each cell holding one entry's statistics: the
// result is registered when the token leaves the last cell, and a new request
// may start as it is shown (busy covers the scan). Round robin, an empty table
// and unsupported methods answer the cycle after the request and busy stays low.
// Updates likewise leave busy low, one request per cycle outside a scan.
// The APB port holds method (0x0) and server_count (0x4); write them only when
// no request is in flight. Reset clears the table, the round-robin pointer and
// both registers; no scan or result is pending after reset.
module upstream_load_balance_selector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [lbs_pkg::IDX_W-1:0]   entry,
	input  wire logic [lbs_pkg::IDLE_W-1:0]  idle_conns,
	input  wire logic [lbs_pkg::RTT_W-1:0]   rtt_us,
	output logic                             done,
	output logic                             found,
	output logic [lbs_pkg::IDX_W-1:0]        chosen,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lbs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lbs_pkg::PDATA_W-1:0] pwdata,
	output logic [lbs_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);
	import lbs_pkg::*;

	logic [METH_W-1:0] method_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_live;
	logic              cfg_wr;
	logic              reg_sel;
	scan_t             link [NUM_CELLS+1];
	wr_t               wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= '0;
			count_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_METHOD: method_q <= pwdata[METH_W-1:0];
				REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_METHOD: prdata = PDATA_W'(method_q);
			REG_COUNT:  prdata = PDATA_W'(count_q);
			default:    prdata = '0;
		endcase
	end

	assign n_live = (count_q > CNT_W'(NUM_CELLS)) ? CNT_W'(NUM_CELLS) : count_q;

	lbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.entry      (entry),
		.idle_conns (idle_conns),
		.rtt_us     (rtt_us),
		.method     (method_t'(method_q)),
		.n_live     (n_live),
		.scan_tail  (link[NUM_CELLS]),
		.scan_head  (link[0]),
		.wr         (wr),
		.busy       (busy),
		.done       (done),
		.found      (found),
		.chosen     (chosen)
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.n_live   (n_live),
			.wr       (wr),
			.scan_in  (link[i]),
			.scan_out (link[i+1])
		);
	end

	// a token leaving the row always produces a result next cycle
	a_tail_done: assert property (@(posedge clk) disable iff (!arst_n)
		link[NUM_CELLS].valid |=> done)
		else $error("scan finished without a result");

	// results only appear once the scan has released busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// no table write may land while a scan is in flight
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr.en)
		else $error("table written during scan");

	a_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (chosen == '0))
		else $error("nonzero index without a selection");

endmodule
`default_nettype wire

// ===== tb/tb_upstream_load_balance_selector.sv =====
`default_nettype none
module tb_upstream_load_balance_selector;
	timeunit 1ns;
	timeprecision 1ps;

	import lbs_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 24;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned RAND_PHASES     = 24;
	localparam int unsigned ITEMS_PER_PHASE = 81;
	localparam int unsigned QUIET_PHASES    = 3;

	// highest code of the method field, not a defined method
	localparam logic [METH_W-1:0] METH_TOP_UNDEF = 3'd7;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  idx;
		logic [IDLE_W-1:0] idle;
		logic [RTT_W-1:0]  rtt;
	} req_item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] chosen;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = REQ_SELECT;
	logic [IDX_W-1:0] entry = '0;
	logic [IDLE_W-1:0] idle_conns = '0;
	logic [RTT_W-1:0] rtt_us = '0;
	logic done;
	logic found;
	logic [IDX_W-1:0] chosen;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	upstream_load_balance_selector dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the selector's registers and table
	logic [METH_W-1:0] cfg_method = METH_LOW_RTT;
	logic [CNT_W-1:0]  cfg_count = '0;
	logic [IDLE_W-1:0] idle_tbl [NUM_CELLS];
	logic [RTT_W-1:0]  rtt_tbl [NUM_CELLS];
	logic [IDX_W-1:0]  rr_last = '0;
	logic              rr_valid = 1'b0;

	req_item_t pending_reqs [$];
	pick_t     expected_picks [$];
	pick_t     mon_want;

	int  n_errors = 0;
	int  n_selects = 0;
	int  n_updates = 0;
	int  n_settings = 0;
	int  gap_left = 0;
	int  stall_cycles = 0;
	bit  quiet_tail = 1'b0;
	bit  drive_req;

	initial begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			idle_tbl[i] = '0;
			rtt_tbl[i] = '0;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		n_errors++;
	endtask

	// updates the shadow table, or works out the pick a select request must give
	function automatic void apply_request(input req_item_t r);
		int unsigned n;
		int unsigned nxt;
		logic [IDX_W-1:0] best;
		bit hit;
		pick_t p;

		if (r.req_type == REQ_UPDATE) begin
			idle_tbl[r.idx] = r.idle;
			rtt_tbl[r.idx] = r.rtt;
			n_updates++;
			return;
		end
		n_selects++;
		n = (cfg_count > NUM_CELLS) ? NUM_CELLS : cfg_count;
		best = '0;
		p.found = (n != 0);
		if (n != 0) begin
			case (cfg_method)
				METH_LOW_RTT: begin
					for (int i = 1; i < n; i++)
						if (rtt_tbl[i] < rtt_tbl[best]) best = IDX_W'(i);
				end
				METH_MOST_IDLE: begin
					for (int i = 1; i < n; i++)
						if (idle_tbl[i] > idle_tbl[best]) best = IDX_W'(i);
				end
				METH_ROUND_ROBIN: begin
					// under two servers: entry 0, pointer left alone
					if (n >= 2) begin
						nxt = rr_valid ? rr_last + 1 : 0;
						if (nxt >= n) nxt = 0;
						rr_last = IDX_W'(nxt);
						rr_valid = 1'b1;
						best = IDX_W'(nxt);
					end
				end
				METH_FIRST_IDLE: begin
					hit = 1'b0;
					for (int i = 0; i < n; i++)
						if (!hit && idle_tbl[i] != 0) begin
							best = IDX_W'(i);
							hit = 1'b1;
						end
				end
				default: p.found = 1'b0;
			endcase
		end
		p.chosen = p.found ? best : '0;
		expected_picks.push_back(p);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) apply_request(pending_reqs.pop_front());
			if (gap_left != 0) begin
				gap_left--;
				drive_req = 1'b0;
			end else if (!quiet_tail && pending_reqs.size() != 0 &&
				$urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(0, 5);
				drive_req = 1'b0;
			end else begin
				drive_req = (pending_reqs.size() != 0);
			end
			start <= drive_req;
			if (drive_req) begin
				req_type <= pending_reqs[0].req_type;
				entry <= pending_reqs[0].idx;
				idle_conns <= pending_reqs[0].idle;
				rtt_us <= pending_reqs[0].rtt;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_picks.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: found=%0b chosen=%0d",
					found, chosen));
			end else begin
				mon_want = expected_picks.pop_front();
				if (found !== mon_want.found)
					report_mismatch($sformatf("found %0b, want %0b", found, mon_want.found));
				if (chosen !== mon_want.chosen)
					report_mismatch($sformatf("chosen %0d, want %0d", chosen, mon_want.chosen));
			end
		end
	end

	// watchdog: cycles with no request, result or register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pwrite && pready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic add_request(input logic rt, input logic [IDX_W-1:0] e,
		input logic [IDLE_W-1:0] idl, input logic [RTT_W-1:0] rtt);
		req_item_t r;
		r.req_type = rt;
		r.idx = e;
		r.idle = idl;
		r.rtt = rtt;
		pending_reqs.push_back(r);
	endtask

	task automatic add_selects(input int cnt);
		@(negedge clk);
		repeat (cnt) add_request(REQ_SELECT, IDX_W'($urandom), IDLE_W'($urandom), $urandom);
	endtask

	// block idle: queue empty, start low, every pick back, scan flushed
	task automatic settle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_picks.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_METHOD)
			cfg_method = val[METH_W-1:0];
		else
			cfg_count = val[CNT_W-1:0];
	endtask

	task automatic set_config(input logic [METH_W-1:0] m, input logic [CNT_W-1:0] c);
		settle();
		apb_write(REG_METHOD, PDATA_W'(m));
		apb_write(REG_COUNT, PDATA_W'(c));
		n_settings++;
	endtask

	function automatic logic [RTT_W-1:0] rand_rtt();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return RTT_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDLE_W-1:0] rand_idle();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return IDLE_W'($urandom_range(0, 3));
			default: return IDLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int upd_pct;
		int sel;
		logic [METH_W-1:0] m;
		logic [CNT_W-1:0] c;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty table after reset, then the field extremes at both ends of the table
		@(negedge clk);
		add_request(REQ_SELECT, '0, '0, '0);
		add_request(REQ_UPDATE, IDX_W'(NUM_CELLS - 1), '1, '0);
		add_request(REQ_UPDATE, '0, '0, '1);
		add_request(REQ_SELECT, '1, '1, '1);
		set_config(METH_LOW_RTT, CNT_W'(NUM_CELLS));
		add_selects(1);
		set_config(METH_MOST_IDLE, CNT_W'(NUM_CELLS));
		add_selects(1);
		set_config(METH_ROUND_ROBIN, CNT_W'(NUM_CELLS));
		add_selects(2);
		set_config(METH_FIRST_IDLE, CNT_W'(NUM_CELLS));
		add_selects(1);
		// nothing idle in a one-server table
		set_config(METH_FIRST_IDLE, 5'd1);
		add_selects(1);
		set_config(METH_RANDOM, CNT_W'(NUM_CELLS));
		add_selects(1);
		set_config(METH_TOP_UNDEF, CNT_W'(NUM_CELLS));
		add_selects(1);
		// count past the table, then one server, then a stale pointer
		set_config(METH_ROUND_ROBIN, 5'd31);
		add_selects(1);
		set_config(METH_ROUND_ROBIN, 5'd1);
		add_selects(1);
		set_config(METH_ROUND_ROBIN, 5'd2);
		add_selects(1);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			sel = $urandom_range(0, 8);
			m = (sel < 8) ? METH_W'(sel / 2) : METH_W'($urandom_range(METH_RANDOM, METH_TOP_UNDEF));
			case ($urandom_range(0, 9))
				0: c = '0;
				1: c = 5'd1;
				2: c = 5'd2;
				3: c = CNT_W'(NUM_CELLS);
				4: c = CNT_W'($urandom_range(NUM_CELLS + 1, 31));
				default: c = CNT_W'($urandom_range(1, NUM_CELLS));
			endcase
			set_config(m, c);
			quiet_tail = (ph >= RAND_PHASES - QUIET_PHASES);
			upd_pct = $urandom_range(15, 50);
			@(negedge clk);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 99) < upd_pct)
					add_request(REQ_UPDATE, IDX_W'($urandom_range(0, NUM_CELLS - 1)),
						rand_idle(), rand_rtt());
				else
					add_request(REQ_SELECT, IDX_W'($urandom), IDLE_W'($urandom), $urandom);
			end
		end

		settle();
		if (expected_picks.size() != 0)
			report_mismatch($sformatf("%0d picks never arrived", expected_picks.size()));
		$display("Run covered %0d selections and %0d table updates", n_selects, n_updates);
		$display("over %0d method/count settings; %0d mismatches", n_settings, n_errors);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
